// ----- rtl/bitmap_id_allocator_defines.svh -----
// assertion macros for the bitmap id allocator
`ifndef BITMAP_ID_ALLOCATOR_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define BIA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define BIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define BIA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BIA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/bia_pkg.sv -----
package bia_pkg;

    localparam int ID_SPACE  = 1024;
    localparam int WORD_BITS = 32;
    localparam int MAP_WORDS = ID_SPACE / WORD_BITS;
    localparam int ID_W      = 11;
    localparam int POS_W     = $clog2(ID_SPACE);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WADDR_W   = POS_W - BIT_W;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [ID_W-1:0] LOWEST_ID_RST = ID_W'(100);
    localparam logic [ID_W-1:0] ID_LIMIT_RST  = ID_W'(1000);

    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_LIMIT  = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REL,
        ST_RESP
    } seq_state_t;

    typedef struct packed {
        logic                 rd_en;
        logic [WADDR_W-1:0]   rd_addr;
        logic                 wr_en;
        logic [WADDR_W-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } map_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   granted;
    } result_t;

endpackage

// ----- rtl/bia_map.sv -----
module bia_map
    import bia_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  map_req_t             req,
    output logic [WORD_BITS-1:0] rd_word
);

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] vld_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_vld_reg;

    // word valid bits, a word never written reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_word = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/bia_ffz.sv -----
module bia_ffz
    import bia_pkg::*;
(
    input  logic [WORD_BITS-1:0] word,
    input  logic [BIT_W-1:0]     lo_bit,
    input  logic [BIT_W-1:0]     hi_bit,
    output logic                 found,
    output logic [BIT_W-1:0]     bit_idx
);

    logic [WORD_BITS-1:0] masked;

    // bits outside the window count as used
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            masked[i] = word[i] | (BIT_W'(i) < lo_bit) | (BIT_W'(i) > hi_bit);
        end
    end

    // lowest zero bit
    always_comb
    begin
        found   = 1'b0;
        bit_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!masked[i])
            begin
                found   = 1'b1;
                bit_idx = BIT_W'(i);
            end
        end
    end

endmodule

// ----- rtl/bia_seq.sv -----
module bia_seq
    import bia_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 kind,
    input  logic [ID_W-1:0]      release_id,
    input  logic [ID_W-1:0]      lowest_id,
    input  logic [ID_W-1:0]      id_limit,
    input  logic [WORD_BITS-1:0] rd_word,
    output map_req_t             map_req,
    output logic                 idle,
    output logic                 done,
    output result_t              result
);

    seq_state_t         state_reg, state_next;
    logic [WADDR_W-1:0] cur_w_reg, cur_w_next;
    logic [WADDR_W-1:0] start_w_reg, start_w_next;
    logic [WADDR_W-1:0] end_w_reg, end_w_next;
    logic [BIT_W-1:0]   start_bit_reg, start_bit_next;
    logic [BIT_W-1:0]   end_bit_reg, end_bit_next;
    result_t            res_reg, res_next;

    logic [ID_W-1:0]    first_id;
    logic [ID_W-1:0]    last_raw;
    logic [ID_W-1:0]    last_id;
    logic               range_empty;
    logic [ID_W-1:0]    spos;
    logic [ID_W-1:0]    epos;
    logic [ID_W-1:0]    rpos;
    logic               rel_bad;
    logic [BIT_W-1:0]   lo_bit;
    logic [BIT_W-1:0]   hi_bit;
    logic               found;
    logic [BIT_W-1:0]   bit_idx;
    logic               last_word;

    // request decode at accept
    always_comb
    begin
        first_id    = (lowest_id == '0) ? ID_W'(1) : lowest_id;
        last_raw    = (id_limit == '0) ? '0 : id_limit - ID_W'(1);
        last_id     = (last_raw > ID_W'(ID_SPACE)) ? ID_W'(ID_SPACE) : last_raw;
        range_empty = first_id > last_id;
        spos        = first_id - ID_W'(1);
        epos        = last_id - ID_W'(1);
        rpos        = release_id - ID_W'(1);
        rel_bad     = (release_id == '0) || (release_id > ID_W'(ID_SPACE));
    end

    assign lo_bit    = (cur_w_reg == start_w_reg) ? start_bit_reg : '0;
    assign hi_bit    = (cur_w_reg == end_w_reg) ? end_bit_reg : BIT_W'(WORD_BITS - 1);
    assign last_word = cur_w_reg == end_w_reg;

    bia_ffz u_ffz (
        .word    (rd_word),
        .lo_bit  (lo_bit),
        .hi_bit  (hi_bit),
        .found   (found),
        .bit_idx (bit_idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_w_reg     <= cur_w_next;
        start_w_reg   <= start_w_next;
        end_w_reg     <= end_w_next;
        start_bit_reg <= start_bit_next;
        end_bit_reg   <= end_bit_next;
        res_reg       <= res_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_ALLOC)
                    begin
                        state_next = range_empty ? ST_RESP : ST_SCAN;
                    end
                    else
                    begin
                        state_next = rel_bad ? ST_RESP : ST_REL;
                    end
                end
            end
            ST_SCAN:
            begin
                if (found || last_word)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_REL:  state_next = ST_RESP;
            ST_RESP: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath registers
    always_comb
    begin
        cur_w_next     = cur_w_reg;
        start_w_next   = start_w_reg;
        end_w_next     = end_w_reg;
        start_bit_next = start_bit_reg;
        end_bit_next   = end_bit_reg;
        res_next       = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    end_w_next   = epos[POS_W-1:BIT_W];
                    end_bit_next = epos[BIT_W-1:0];
                    start_w_next = spos[POS_W-1:BIT_W];
                    if (kind == KIND_ALLOC)
                    begin
                        cur_w_next     = spos[POS_W-1:BIT_W];
                        start_bit_next = spos[BIT_W-1:0];
                        res_next       = '{status: STAT_FULL, granted: '0};
                    end
                    else
                    begin
                        cur_w_next     = rpos[POS_W-1:BIT_W];
                        start_bit_next = rpos[BIT_W-1:0];
                        res_next       = '{status: rel_bad ? STAT_BAD : STAT_DONE,
                                           granted: '0};
                    end
                end
            end
            ST_SCAN:
            begin
                if (found)
                begin
                    res_next = '{status: STAT_DONE,
                                 granted: ID_W'({cur_w_reg, bit_idx}) + ID_W'(1)};
                end
                else if (!last_word)
                begin
                    cur_w_next = cur_w_reg + WADDR_W'(1);
                end
            end
            ST_REL:  ;
            ST_RESP: ;
            default: ;
        endcase
    end

    // outputs
    always_comb
    begin
        map_req = '0;
        idle    = 1'b0;
        done    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idle            = 1'b1;
                map_req.rd_en   = start;
                map_req.rd_addr = (kind == KIND_ALLOC) ? spos[POS_W-1:BIT_W]
                                                       : rpos[POS_W-1:BIT_W];
            end
            ST_SCAN:
            begin
                map_req.rd_en   = !found && !last_word;
                map_req.rd_addr = cur_w_reg + WADDR_W'(1);
                map_req.wr_en   = found;
                map_req.wr_addr = cur_w_reg;
                map_req.wr_data = rd_word | (WORD_BITS'(1) << bit_idx);
            end
            ST_REL:
            begin
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = cur_w_reg;
                map_req.wr_data = rd_word & ~(WORD_BITS'(1) << start_bit_reg);
            end
            ST_RESP:
            begin
                done = 1'b1;
            end
            default: ;
        endcase
    end

    assign result = res_reg;

endmodule

// ----- rtl/bitmap_id_allocator.sv -----
// bitmap id allocator, lowest free identifier first
// s_axis channel takes one request per transaction: s_tuser is the kind
// (allocate or release), s_tdata carries the release identifier
// m_axis channel returns one result per request: m_tuser is the status,
// m_tdata the granted identifier (zero unless an allocate succeeded)
// cfg channel writes lowest_id (index 0) and id_limit (index 1); cfg_ready
// is always high, writes to other indexes are dropped
// one request at a time: s_tready is low from accept until the result
// has been taken on m_axis
// allocate: scans the 32-bit bitmap words in turn, from the word holding
// lowest_id up to the word holding id_limit-1, stops at the first word with
// a free identifier in the window or at the last word, then responds
// release: modify-write, then respond; bad release or empty range: straight
// to respond; a new request can be accepted in the cycle after the result
// transaction
// reset clears the whole bitmap at once through per-word valid bits, and
// loads lowest_id = 100, id_limit = 1000; no clearing pass is needed
// a stalled m_tready holds the result in the output register and keeps
// s_tready low
`include "bitmap_id_allocator_defines.svh"

module bitmap_id_allocator
    import bia_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,    // [10:0] release_id, [15:11] zero
    input  logic                 s_tuser,    // [0] kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,    // [10:0] granted_id, [15:11] zero
    output logic [STAT_W-1:0]    m_tuser,    // [1:0] status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_data
);

    logic [ID_W-1:0]      lowest_id_reg;
    logic [ID_W-1:0]      id_limit_reg;
    logic                 out_valid_reg;
    result_t              out_res_reg;
    logic                 s_accept;
    logic                 seq_idle;
    logic                 seq_done;
    result_t              seq_result;
    map_req_t             map_req;
    logic [WORD_BITS-1:0] rd_word;

    assign cfg_ready = 1'b1;
    assign s_tready  = seq_idle && !out_valid_reg;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_id_reg <= LOWEST_ID_RST;
            id_limit_reg  <= ID_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_LOWEST_ID)
            begin
                lowest_id_reg <= cfg_data;
            end
            else if (cfg_index == CFG_ID_LIMIT)
            begin
                id_limit_reg <= cfg_data;
            end
        end
    end

    bia_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (map_req),
        .rd_word (rd_word)
    );

    bia_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (s_accept),
        .kind       (s_tuser),
        .release_id (s_tdata[ID_W-1:0]),
        .lowest_id  (lowest_id_reg),
        .id_limit   (id_limit_reg),
        .rd_word    (rd_word),
        .map_req    (map_req),
        .idle       (seq_idle),
        .done       (seq_done),
        .result     (seq_result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_done)
        begin
            out_res_reg <= seq_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {{(16 - ID_W){1'b0}}, out_res_reg.granted};

    `BIA_ASSERT_IMPLY(a_no_accept_with_pending, clk, rst_n, s_tready, !m_tvalid)
    `BIA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_accept, !s_tready)
    `BIA_ASSERT_IMPLY(a_grant_zero, clk, rst_n, m_tvalid && (m_tuser != STAT_DONE), m_tdata == '0)

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import bia_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct {
        logic            kind;
        logic [ID_W-1:0] rid;
    } request_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic                 s_tuser = KIND_ALLOC;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic [STAT_W-1:0]    m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LOWEST_ID;
    logic [ID_W-1:0]      cfg_data = '0;

    request_t          request_queue[$];
    result_t           pending_results[$];
    logic [ID_SPACE-1:0] id_used;
    logic [ID_W-1:0]   cur_lowest;
    logic [ID_W-1:0]   cur_limit;
    int                idle_pct = 32;
    int                error_count = 0;
    int                cycle_count = 0;

    bitmap_id_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // lowest free identifier in the window, or full / bad status; a good release frees its identifier
    function automatic void predict_request(input logic kind, input logic [ID_W-1:0] rid);
        result_t res;
        int      first;
        int      last;
        int      id;
        res.status  = STAT_FULL;
        res.granted = '0;
        if (kind == KIND_ALLOC)
        begin
            first = (cur_lowest == 0) ? 1 : int'(cur_lowest);
            last  = (cur_limit == 0) ? 0 : int'(cur_limit) - 1;
            if (last > ID_SPACE)
                last = ID_SPACE;
            id = first;
            while (id <= last)
            begin
                if (!id_used[id-1])
                begin
                    id_used[id-1] = 1'b1;
                    res.status    = STAT_DONE;
                    res.granted   = ID_W'(id);
                    break;
                end
                id++;
            end
        end
        else if (rid == 0 || int'(rid) > ID_SPACE)
        begin
            res.status = STAT_BAD;
        end
        else
        begin
            id_used[rid-1] = 1'b0;
            res.status     = STAT_DONE;
        end
        pending_results.push_back(res);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata[ID_W-1:0]);
            if (!s_tvalid || s_tready)
            begin
                if (request_queue.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    request_t req;
                    req = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= req.kind;
                    s_tdata  <= 16'(req.rid);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= idle_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: status %0d granted_id %0d",
                       m_tuser, m_tdata);
                error_count++;
            end
            else
            begin
                result_t exp_res;
                exp_res = pending_results.pop_front();
                if (m_tuser !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_res.status, m_tuser);
                    error_count++;
                end
                if (m_tdata !== 16'(exp_res.granted))
                begin
                    $error("granted_id: expected %0d, actual %0d", exp_res.granted, m_tdata);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bitmap_id_allocator regression: fail");
            $finish;
        end
    end

    task automatic push_request(input logic kind, input int rid);
        request_t req;
        req.kind = kind;
        req.rid  = ID_W'(rid);
        request_queue.push_back(req);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (request_queue.size() != 0 || s_tvalid || pending_results.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= ID_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_LOWEST_ID: cur_lowest = ID_W'(value);
            CFG_ID_LIMIT:  cur_limit  = ID_W'(value);
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_window(input int lowest, input int limit);
        wait_idle();
        write_reg(CFG_LOWEST_ID, lowest);
        write_reg(CFG_ID_LIMIT, limit);
    endtask

    // release targets mostly near the window, some anywhere
    task automatic fill_random(input int count, input int alloc_pct, input int lo, input int hi);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < alloc_pct)
            begin
                push_request(KIND_ALLOC, $urandom_range(2047));
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    push_request(KIND_RELEASE, $urandom_range(hi, lo));
                else if (roll < 85)
                    push_request(KIND_RELEASE, $urandom_range(ID_SPACE, 1));
                else
                    push_request(KIND_RELEASE, $urandom_range(2047));
            end
        end
    endtask

    initial
    begin
        int lo;
        id_used    = '0;
        cur_lowest = LOWEST_ID_RST;
        cur_limit  = ID_LIMIT_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset window 100..999
        push_request(KIND_ALLOC, 0);
        push_request(KIND_ALLOC, 2047);
        push_request(KIND_ALLOC, 0);
        push_request(KIND_RELEASE, 101);
        push_request(KIND_ALLOC, 0);
        push_request(KIND_RELEASE, 0);
        push_request(KIND_RELEASE, ID_SPACE + 1);
        push_request(KIND_RELEASE, 2047);
        push_request(KIND_RELEASE, ID_SPACE);
        push_request(KIND_RELEASE, 1);
        push_request(KIND_RELEASE, 100);
        push_request(KIND_RELEASE, 100);

        // lowest of zero maps to one
        set_window(0, 3);
        write_reg(CFG_SPARE_2, 2047);
        push_request(KIND_ALLOC, 0);
        push_request(KIND_ALLOC, 0);
        push_request(KIND_ALLOC, 0);
        push_request(KIND_RELEASE, 2);
        push_request(KIND_ALLOC, 0);

        set_window(ID_SPACE, ID_SPACE + 1);
        write_reg(CFG_SPARE_3, 5);
        push_request(KIND_ALLOC, 0);
        push_request(KIND_ALLOC, 0);
        push_request(KIND_RELEASE, ID_SPACE);

        // empty ranges
        set_window(2047, 2047);
        push_request(KIND_ALLOC, 0);
        set_window(5, 0);
        push_request(KIND_ALLOC, 0);

        // limit past the space
        set_window(1000, 2047);
        push_request(KIND_ALLOC, 0);
        push_request(KIND_ALLOC, 0);

        set_window(1, ID_SPACE + 1);
        fill_random(160, 60, 1, ID_SPACE);

        set_window(900, 940);
        fill_random(160, 70, 890, 950);

        set_window(0, 2047);
        idle_pct = 0;
        fill_random(160, 50, 1, ID_SPACE);

        wait_idle();
        idle_pct = 32;
        lo = $urandom_range(1000, 1);
        set_window(lo, lo + $urandom_range(24, 1));
        fill_random(160, 65, lo, lo + 24);

        set_window(1020, ID_SPACE + 1);
        fill_random(60, 55, 1015, ID_SPACE);

        set_window(500, 600);
        fill_random(160, 40, 480, 620);

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("results still expected at end: %0d", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("bitmap_id_allocator regression: pass");
        else
            $display("bitmap_id_allocator regression: fail");
        $finish;
    end

endmodule

// ----- bitmap_id_allocator.f -----
+incdir+rtl
rtl/bia_pkg.sv
rtl/bia_map.sv
rtl/bia_ffz.sv
rtl/bia_seq.sv
rtl/bitmap_id_allocator.sv
verif/tb_top.sv
